FILE: hdl/mpws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mpws_pkg;

    localparam int BYTE_BITS    = 8;
    localparam int WORD_BITS    = 64;
    localparam int LEN_BITS     = 4;
    localparam int OFFSET_BITS  = 16;
    localparam int RANGE_BITS   = 16;
    localparam int START_BITS   = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam logic [BYTE_BITS-1:0] BYTE_MASK = 8'hff;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PATTERN_VALUE  = 3'd0,
        CFG_PATTERN_MASK   = 3'd1,
        CFG_PATTERN_LENGTH = 3'd2,
        CFG_START_OFFSET   = 3'd3,
        CFG_RANGE_LENGTH   = 3'd4
    } cfg_index_t;

    // Per-transaction summary handed from the cell row to the decision logic.
    typedef struct packed {
        logic accept;
        logic last;
        logic window_hit;
    } step_t;

endpackage

`default_nettype wire

FILE: hdl/mpws_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mpws_stream_if;
    logic                              valid;
    logic                              ready;
    logic [mpws_pkg::BYTE_BITS-1:0]    data_byte;
    logic                              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mpws_result_if;
    logic                              valid;
    logic                              ready;
    logic                              matched;
    logic [mpws_pkg::START_BITS-1:0]   match_start;

    modport source (output valid, output matched, output match_start, input ready);
    modport sink (input valid, input matched, input match_start, output ready);
endinterface

interface mpws_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mpws_pkg::CFG_IDX_BITS-1:0] index;
    logic [mpws_pkg::WORD_BITS-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/mpws_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module mpws_cell #(
    parameter int CELL_INDEX = 0
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              shift_en,
    input  wire logic                              clear,
    input  wire logic [mpws_pkg::BYTE_BITS-1:0]    byte_in,
    input  wire logic [mpws_pkg::LEN_BITS-1:0]     used_len,
    input  wire logic [mpws_pkg::WORD_BITS-1:0]    pattern_value,
    input  wire logic [mpws_pkg::WORD_BITS-1:0]    pattern_mask,
    output logic      [mpws_pkg::BYTE_BITS-1:0]    byte_out,
    output logic                                   hit
);

    logic [mpws_pkg::BYTE_BITS-1:0] byte_reg;
    logic [mpws_pkg::BYTE_BITS-1:0] byte_next;
    logic [mpws_pkg::LEN_BITS-1:0]  idx;
    logic                           in_use;
    logic [2:0]                     sel;
    logic [mpws_pkg::BYTE_BITS-1:0] mask_byte;
    logic [mpws_pkg::BYTE_BITS-1:0] value_byte;

    // The cell at window place j is compared against pattern byte len-1-j,
    // because the newest byte sits in cell zero.
    always_comb
    begin
        idx        = mpws_pkg::LEN_BITS'(CELL_INDEX);
        in_use     = idx < used_len;
        sel        = 3'(used_len - 4'd1 - idx);
        mask_byte  = pattern_mask[{sel, 3'b000} +: mpws_pkg::BYTE_BITS];
        value_byte = pattern_value[{sel, 3'b000} +: mpws_pkg::BYTE_BITS];
        hit        = !in_use || ((byte_in & mask_byte) == (value_byte & mask_byte));
    end

    always_comb
    begin
        byte_next = byte_reg;
        if (shift_en)
        begin
            byte_next = clear ? '0 : (byte_in & mpws_pkg::BYTE_MASK);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

endmodule

`default_nettype wire

FILE: hdl/mpws_decide.sv
`timescale 1ns / 1ps
`default_nettype none

module mpws_decide #(
    parameter int POSITION_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire mpws_pkg::step_t                    step,
    input  wire logic [mpws_pkg::LEN_BITS-1:0]      used_len,
    input  wire logic [mpws_pkg::OFFSET_BITS-1:0]   start_offset,
    input  wire logic [mpws_pkg::RANGE_BITS-1:0]    range_length,
    output logic                                    in_ready,
    mpws_result_if.source                           result
);

    localparam int PW = POSITION_BITS + 1;
    localparam int W  = (PW + 1 > 18) ? PW + 1 : 18;

    logic [PW-1:0]                     position_reg;
    logic [PW-1:0]                     position_next;
    logic                              decided_reg;
    logic                              decided_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              matched_reg;
    logic                              matched_next;
    logic [mpws_pkg::START_BITS-1:0]   match_start_reg;
    logic [mpws_pkg::START_BITS-1:0]   match_start_next;

    logic [W-1:0] pos_ext;
    logic [W-1:0] len_ext;
    logic [W-1:0] off_ext;
    logic [W-1:0] end_ext;
    logic [W-1:0] start_pos;
    logic         pos_sat;
    logic         have_start;
    logic         hit;
    logic         give;

    assign in_ready = !out_valid_reg || result.ready;

    always_comb
    begin
        pos_ext    = W'(position_reg);
        len_ext    = W'(used_len);
        off_ext    = W'(start_offset);
        end_ext    = W'(start_offset) + W'(range_length);
        start_pos  = pos_ext + W'(1) - len_ext;
        pos_sat    = &position_reg;
        have_start = (pos_ext + W'(1)) >= len_ext;
        hit        = have_start && step.window_hit
                     && (start_pos >= off_ext) && (start_pos < end_ext);
        // A saturated position ends the search with a no-match result.
        give       = !decided_reg && (pos_sat || (range_length == '0) || step.last
                     || (have_start && (hit || (start_pos + W'(1) >= end_ext))));
    end

    always_comb
    begin
        position_next    = position_reg;
        decided_next     = decided_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        matched_next     = matched_reg;
        match_start_next = match_start_reg;
        if (step.accept)
        begin
            if (step.last)
            begin
                position_next = '0;
                decided_next  = 1'b0;
            end
            else
            begin
                if (!pos_sat)
                begin
                    position_next = position_reg + PW'(1);
                end
                if (give)
                begin
                    decided_next = 1'b1;
                end
            end
            if (give)
            begin
                out_valid_next   = 1'b1;
                matched_next     = hit && !pos_sat && (range_length != '0);
                match_start_next = (hit && !pos_sat && (range_length != '0))
                                   ? start_pos[mpws_pkg::START_BITS-1:0] : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg  <= '0;
            decided_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            position_reg  <= position_next;
            decided_reg   <= decided_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg     <= matched_next;
        match_start_reg <= match_start_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.matched     = matched_reg;
    assign result.match_start = match_start_reg;

    a_nomatch_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !matched_reg) |-> (match_start_reg == '0))
        else $error("no-match result carries a nonzero start");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (step.accept && step.last) |=> (position_reg == '0 && !decided_reg))
        else $error("stream state not cleared after the last byte");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (step.accept && decided_reg) |=> !out_valid_reg)
        else $error("second result given for one stream");

    a_position_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step.accept |=> $stable(position_reg))
        else $error("position moved without a transaction");

endmodule

`default_nettype wire

FILE: hdl/masked_pattern_window_search.sv
`timescale 1ns / 1ps
`default_nettype none

// Masked byte pattern search over a stream. One byte transaction can be taken
// every clock cycle: the incoming byte shifts into a row of PATTERN_BYTES
// window cells, each of which compares its byte against the matching pattern
// byte under the mask, and the AND of the cell results together with the
// position count decides the transaction in that same cycle. A result appears
// on the result channel in the cycle after the byte that decides it, and the
// byte channel keeps accepting while that result waits, as long as it is
// taken in the same cycle. At most one result is given per stream; the byte
// after one marked last starts a new stream at position zero. Configuration
// writes are accepted every cycle and are meant to be made between streams.
module masked_pattern_window_search #(
    parameter int PATTERN_BYTES = 8,
    parameter int POSITION_BITS = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    mpws_stream_if.sink     stream,
    mpws_result_if.source   result,
    mpws_cfg_if.sink        cfg
);

    logic [mpws_pkg::WORD_BITS-1:0]   pattern_value_reg;
    logic [mpws_pkg::WORD_BITS-1:0]   pattern_mask_reg;
    logic [mpws_pkg::LEN_BITS-1:0]    pattern_length_reg;
    logic [mpws_pkg::OFFSET_BITS-1:0] start_offset_reg;
    logic [mpws_pkg::RANGE_BITS-1:0]  range_length_reg;

    logic [mpws_pkg::LEN_BITS-1:0]    used_len;
    logic                             in_ready;
    logic                             accept;
    logic [mpws_pkg::BYTE_BITS-1:0]   window [PATTERN_BYTES];
    logic [PATTERN_BYTES-1:0]         cell_hit;
    mpws_pkg::step_t                  step;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_value_reg  <= '0;
            pattern_mask_reg   <= '1;
            pattern_length_reg <= mpws_pkg::LEN_BITS'(1);
            start_offset_reg   <= '0;
            range_length_reg   <= mpws_pkg::RANGE_BITS'(1);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                mpws_pkg::CFG_PATTERN_VALUE:
                    pattern_value_reg <= cfg.data;
                mpws_pkg::CFG_PATTERN_MASK:
                    pattern_mask_reg <= cfg.data;
                mpws_pkg::CFG_PATTERN_LENGTH:
                    pattern_length_reg <= cfg.data[mpws_pkg::LEN_BITS-1:0];
                mpws_pkg::CFG_START_OFFSET:
                    start_offset_reg <= cfg.data[mpws_pkg::OFFSET_BITS-1:0];
                mpws_pkg::CFG_RANGE_LENGTH:
                    range_length_reg <= cfg.data[mpws_pkg::RANGE_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    // A length of zero counts as one; a length above the window counts as full.
    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            used_len = mpws_pkg::LEN_BITS'(1);
        end
        else if (pattern_length_reg > mpws_pkg::LEN_BITS'(PATTERN_BYTES))
        begin
            used_len = mpws_pkg::LEN_BITS'(PATTERN_BYTES);
        end
        else
        begin
            used_len = pattern_length_reg;
        end
    end

    assign stream.ready = in_ready;
    assign accept       = stream.valid && in_ready;

    for (genvar g = 0; g < PATTERN_BYTES; g++)
    begin : g_cell
        logic [mpws_pkg::BYTE_BITS-1:0] feed;
        if (g == 0)
        begin : g_head
            assign feed = stream.data_byte;
        end
        else
        begin : g_body
            assign feed = window[g-1];
        end

        mpws_cell #(
            .CELL_INDEX (g)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .shift_en      (accept),
            .clear         (stream.last_byte),
            .byte_in       (feed),
            .used_len      (used_len),
            .pattern_value (pattern_value_reg),
            .pattern_mask  (pattern_mask_reg),
            .byte_out      (window[g]),
            .hit           (cell_hit[g])
        );
    end

    always_comb
    begin
        step.accept     = accept;
        step.last       = stream.last_byte;
        step.window_hit = &cell_hit;
    end

    mpws_decide #(
        .POSITION_BITS (POSITION_BITS)
    ) u_decide (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .used_len     (used_len),
        .start_offset (start_offset_reg),
        .range_length (range_length_reg),
        .in_ready     (in_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

FILE: tb/masked_pattern_window_search_test.sv
`timescale 1ns / 1ps

module masked_pattern_window_search_test;

    localparam int WINDOW_BYTES   = 8;
    localparam int POSITION_LIMIT = (1 << 17) - 1;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 320;
    localparam logic [mpws_pkg::WORD_BITS-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic                            matched;
        logic [mpws_pkg::START_BITS-1:0] match_start;
    } search_result_t;

    typedef enum int {
        PLANT_NONE,
        PLANT_WHOLE,
        PLANT_BROKEN
    } plant_t;

    class pattern_search_scoreboard;
        logic [mpws_pkg::WORD_BITS-1:0]   pat_value;
        logic [mpws_pkg::WORD_BITS-1:0]   pat_mask;
        logic [mpws_pkg::LEN_BITS-1:0]    pat_len;
        logic [mpws_pkg::OFFSET_BITS-1:0] offset;
        logic [mpws_pkg::RANGE_BITS-1:0]  span;
        logic [mpws_pkg::BYTE_BITS-1:0]   window [WINDOW_BYTES];
        int                               position;
        bit                               decided;
        search_result_t                   pending_q[$];
        int                               mismatches;

        function new();
            pat_value  = '0;
            pat_mask   = ALL_ONES;
            pat_len    = mpws_pkg::LEN_BITS'(1);
            offset     = '0;
            span       = mpws_pkg::RANGE_BITS'(1);
            mismatches = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            foreach (window[i])
                window[i] = '0;
            position = 0;
            decided  = 1'b0;
        endfunction

        function int used_bytes();
            if (pat_len == 0)
                return 1;
            if (pat_len > WINDOW_BYTES)
                return WINDOW_BYTES;
            return int'(pat_len);
        endfunction

        // The newest byte sits in window[0], so pattern byte k lines up with
        // window[len-1-k].
        function bit window_hit(input int len);
            logic [mpws_pkg::BYTE_BITS-1:0] m;
            for (int k = 0; k < len; k++)
            begin
                m = pat_mask[8*k +: 8];
                if ((window[len-1-k] & m) != (pat_value[8*k +: 8] & m))
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void write_reg(input mpws_pkg::cfg_index_t idx,
                                input logic [mpws_pkg::WORD_BITS-1:0] d);
            case (idx)
                mpws_pkg::CFG_PATTERN_VALUE:  pat_value = d;
                mpws_pkg::CFG_PATTERN_MASK:   pat_mask = d;
                mpws_pkg::CFG_PATTERN_LENGTH: pat_len = d[mpws_pkg::LEN_BITS-1:0];
                mpws_pkg::CFG_START_OFFSET:   offset = d[mpws_pkg::OFFSET_BITS-1:0];
                mpws_pkg::CFG_RANGE_LENGTH:   span = d[mpws_pkg::RANGE_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void note_byte(input logic [mpws_pkg::BYTE_BITS-1:0] b, input logic l);
            int             pos;
            int             len;
            int             stop_at;
            int             s;
            bit             give;
            bit             hit;
            search_result_t res;
            pos     = position;
            len     = used_bytes();
            stop_at = int'(offset) + int'(span);
            give    = 1'b0;
            hit     = 1'b0;
            res     = '0;
            for (int i = WINDOW_BYTES - 1; i > 0; i--)
                window[i] = window[i-1];
            window[0] = b;
            if (!decided)
            begin
                if (pos >= POSITION_LIMIT || span == 0)
                    give = 1'b1;
                else if (pos + 1 >= len)
                begin
                    s = pos + 1 - len;
                    if (s >= int'(offset) && s < stop_at && window_hit(len))
                    begin
                        give = 1'b1;
                        hit  = 1'b1;
                        res.match_start = s[mpws_pkg::START_BITS-1:0];
                    end
                    else if (s + 1 >= stop_at)
                        give = 1'b1;
                end
                if (!give && l)
                    give = 1'b1;
            end
            if (position < POSITION_LIMIT)
                position++;
            if (l)
                clear_stream();
            else if (give)
                decided = 1'b1;
            if (give)
            begin
                res.matched = hit;
                pending_q.push_back(res);
            end
        endfunction

        function void check_result(input logic m,
                                   input logic [mpws_pkg::START_BITS-1:0] st);
            search_result_t want;
            if (pending_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: matched=%0b start=%0d, none was due",
                             m, st);
                mismatches++;
                return;
            end
            want = pending_q.pop_front();
            if (want.matched !== m || want.match_start !== st)
            begin
                if (mismatches < 10)
                    $display({"result mismatch: expected matched=%0b start=%0d,",
                              " got matched=%0b start=%0d"},
                             want.matched, want.match_start, m, st);
                mismatches++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   no_idle;
    bit   hold_request;
    int   items_sent;

    pattern_search_scoreboard sb = new();

    mpws_stream_if stream_ch();
    mpws_result_if result_ch();
    mpws_cfg_if    cfg_ch();

    masked_pattern_window_search uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.matched, result_ch.match_start);
    end

    // Result side: random stalls, plus one long hold-off on request so that
    // a waiting result backs up the byte channel.
    initial
    begin
        int hold_count;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                result_ch.ready = 1'b0;
                hold_count = 0;
                while (hold_count < HOLD_CYCLES)
                begin
                    @(negedge clk);
                    hold_count++;
                end
                hold_request = 1'b0;
            end
            result_ch.ready = no_idle || ($urandom_range(0, 99) >= 8);
        end
    end

    initial
    begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_byte(input logic [mpws_pkg::BYTE_BITS-1:0] b, input logic l);
        while (!no_idle && $urandom_range(0, 99) < 8)
        begin
            stream_ch.valid = 1'b0;
            @(negedge clk);
        end
        stream_ch.valid     = 1'b1;
        stream_ch.data_byte = b;
        stream_ch.last_byte = l;
        @(posedge clk);
        while (!stream_ch.ready)
            @(posedge clk);
        sb.note_byte(b, l);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic post_register(input mpws_pkg::cfg_index_t idx,
                                 input logic [mpws_pkg::WORD_BITS-1:0] d);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = d;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.write_reg(idx, d);
        @(negedge clk);
    endtask

    task automatic apply_config(input logic [mpws_pkg::WORD_BITS-1:0] value,
                                input logic [mpws_pkg::WORD_BITS-1:0] mask,
                                input logic [mpws_pkg::WORD_BITS-1:0] length,
                                input logic [mpws_pkg::WORD_BITS-1:0] start,
                                input logic [mpws_pkg::WORD_BITS-1:0] span);
        post_register(mpws_pkg::CFG_PATTERN_VALUE, value);
        post_register(mpws_pkg::CFG_PATTERN_MASK, mask);
        post_register(mpws_pkg::CFG_PATTERN_LENGTH, length);
        post_register(mpws_pkg::CFG_START_OFFSET, start);
        post_register(mpws_pkg::CFG_RANGE_LENGTH, span);
        cfg_ch.valid = 1'b0;
    endtask

    // Also lets the block settle, so a byte that produced no result is done.
    task automatic drain_results();
        stream_ch.valid = 1'b0;
        while (sb.pending_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic random_config();
        logic [mpws_pkg::WORD_BITS-1:0] value;
        logic [mpws_pkg::WORD_BITS-1:0] mask;
        logic [mpws_pkg::WORD_BITS-1:0] length;
        logic [mpws_pkg::WORD_BITS-1:0] start;
        logic [mpws_pkg::WORD_BITS-1:0] span;
        int                             pick;
        value = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 8)
            value = '0;
        else if (pick < 16)
            value = ALL_ONES;
        for (int k = 0; k < WINDOW_BYTES; k++)
        begin
            pick = $urandom_range(0, 99);
            mask[8*k +: 8] = (pick < 50) ? 8'hff : (pick < 65) ? 8'h00 : 8'($urandom);
        end
        if ($urandom_range(0, 9) == 0)
            mask = '0;
        length = {$urandom, $urandom};
        length[mpws_pkg::LEN_BITS-1:0] = mpws_pkg::LEN_BITS'($urandom_range(0, 15));
        start = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 30)
            start[mpws_pkg::OFFSET_BITS-1:0] = '0;
        else if (pick < 80)
            start[mpws_pkg::OFFSET_BITS-1:0] =
                mpws_pkg::OFFSET_BITS'($urandom_range(1, 10));
        else if (pick < 90)
            start[mpws_pkg::OFFSET_BITS-1:0] = 16'hffff;
        span = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 10)
            span[mpws_pkg::RANGE_BITS-1:0] = '0;
        else if (pick < 20)
            span[mpws_pkg::RANGE_BITS-1:0] = 16'hffff;
        else if (pick < 80)
            span[mpws_pkg::RANGE_BITS-1:0] =
                mpws_pkg::RANGE_BITS'($urandom_range(1, 12));
        apply_config(value, mask, length, start, span);
    endtask

    // A broken plant flips the lowest compared bit of one pattern byte, if it has any.
    task automatic random_stream(input int n, input plant_t plant);
        int                             len;
        int                             at;
        int                             k;
        int                             bad;
        logic [mpws_pkg::BYTE_BITS-1:0] b;
        logic [mpws_pkg::BYTE_BITS-1:0] m;
        len = sb.used_bytes();
        at  = (plant != PLANT_NONE && n >= len) ? int'($urandom_range(0, n - len)) : -1;
        bad = int'($urandom_range(0, len - 1));
        for (int i = 0; i < n; i++)
        begin
            b = 8'($urandom);
            if (at >= 0 && i >= at && i < at + len)
            begin
                k = i - at;
                m = sb.pat_mask[8*k +: 8];
                b = (sb.pat_value[8*k +: 8] & m) | (b & ~m);
                if (plant == PLANT_BROKEN && k == bad)
                    b = b ^ (m & (~m + 8'd1));
            end
            send_byte(b, i == n - 1);
        end
    endtask

    initial
    begin
        int     phase_start;
        int     n;
        int     pick;
        bit     hold_done;
        plant_t plant;
        stream_ch.valid     = 1'b0;
        stream_ch.data_byte = '0;
        stream_ch.last_byte = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = mpws_pkg::CFG_PATTERN_VALUE;
        cfg_ch.data         = '0;
        no_idle             = 1'b0;
        hold_request        = 1'b0;
        hold_done           = 1'b0;
        items_sent          = 0;
        rst_n               = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings: a one byte zero pattern at position zero only.
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);
        send_byte(8'hff, 1'b1);

        // Full eight byte pattern; the first seven bytes cannot complete a match.
        drain_results();
        apply_config(ALL_ONES, ALL_ONES, 64'd8, 64'd0, 64'hffff);
        for (int i = 0; i < 8; i++)
            send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);

        // Length zero acts as one; the hit lands on the last byte.
        drain_results();
        apply_config(64'h5a, 64'h0f, 64'd0, 64'd2, 64'd2);
        send_byte(8'h5a, 1'b0);
        send_byte(8'h5a, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hfa, 1'b1);

        // Oversized length with an empty range: no match on the first byte.
        drain_results();
        apply_config(64'h0123456789abcdef, ALL_ONES, 64'd15, 64'd0, 64'd0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);

        // Range never reached before the stream ends.
        drain_results();
        apply_config(64'h0, 64'h0, 64'd3, 64'hffff, 64'd1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b1);

        for (int phase = 0; phase < 6; phase++)
        begin
            drain_results();
            random_config();
            no_idle = (phase == 2);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                if (phase == 3 && !hold_done && items_sent - phase_start > 60)
                begin
                    hold_request = 1'b1;
                    hold_done = 1'b1;
                end
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(21, 48)
                                                : $urandom_range(1, 20);
                pick = $urandom_range(0, 99);
                plant = (pick < 45) ? PLANT_NONE : (pick < 85) ? PLANT_WHOLE : PLANT_BROKEN;
                random_stream(n, plant);
            end
        end
        no_idle = 1'b0;

        drain_results();
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
